### rtl/hct_pkg.sv
// hct_pkg: item types, timer record and operation codes for the countdown timer bank
// no dependencies
`default_nettype none

package hct_pkg;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SET    = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [7:0] LAST_UNIT = 8'd59;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] timer_id;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } in_item_t;

  typedef struct packed {
    logic       running;
    logic [7:0] seconds_left;
  } out_item_t;

  typedef struct packed {
    logic       running;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } timer_t;

  localparam int TIMER_W = $bits(timer_t);

endpackage

`default_nettype wire

### rtl/hms_countdown_timer_bank_top.sv
// hms_countdown_timer_bank_top: timer bank sequencer, record RAM and shared step unit
// depends on hct_pkg, hct_ram, hct_step_unit
//
//   channel   ports                       handshake
//   input     start, busy, in_item        accepted when start && !busy
//   result    out_valid, out_item         one-cycle strobe, no back-pressure
//
// set and expire are written to the RAM at the accept edge
// query reads the RAM at the accept edge, then registers the result strobe in S_QWAIT
// tick passes one timer record per cycle through the step unit,
// read and write-back overlapped on the RAM ports
// reset clears the per-timer valid bits; an unwritten record reads as zero
// busy is high while a tick or query is in flight; results cannot be stalled
`default_nettype none

module hms_countdown_timer_bank_top
  import hct_pkg::*;
#(
  parameter int NUM_TIMERS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int IW = (AW > 3) ? AW : 3;

  typedef enum logic [1:0] {S_IDLE, S_TICK, S_QWAIT} state_t;

  state_t              state_r;
  logic [CW-1:0]       rd_idx_r;
  logic [AW-1:0]       wr_idx_r;
  logic                pend_r;
  logic [AW-1:0]       q_addr_r;
  logic                q_ok_r;
  logic [NUM_TIMERS-1:0] vld_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                accept;
  logic [IW-1:0]       id_ext;
  logic [AW-1:0]       id_addr;
  logic                id_ok;
  logic                rd_go;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  timer_t              ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [TIMER_W-1:0]  ram_rdata;
  logic [AW-1:0]       rd_sel;
  timer_t              entry;
  timer_t              stepped;
  timer_t              load_val;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign id_ext  = IW'(in_item.timer_id);
  assign id_addr = id_ext[AW-1:0];
  assign id_ok   = (32'(in_item.timer_id) < NUM_TIMERS);
  assign rd_go   = (state_r == S_TICK) && (32'(rd_idx_r) < NUM_TIMERS);

  assign rd_sel = (state_r == S_QWAIT) ? q_addr_r : wr_idx_r;
  assign entry  = vld_r[rd_sel] ? timer_t'(ram_rdata) : '0;

  hct_step_unit u_step (
    .cur (entry),
    .nxt (stepped)
  );

  always_comb begin
    load_val.running = (in_item.hours | in_item.minutes | in_item.seconds) != 8'd0;
    load_val.hours   = in_item.hours;
    load_val.minutes = in_item.minutes;
    load_val.seconds = in_item.seconds;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx_r;
    ram_wdata = stepped;
    ram_re    = 1'b0;
    ram_raddr = rd_idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (accept && id_ok) begin
          unique case (in_item.operation)
            OP_SET: begin
              ram_we    = 1'b1;
              ram_waddr = id_addr;
              ram_wdata = load_val;
            end
            OP_EXPIRE: begin
              ram_we    = 1'b1;
              ram_waddr = id_addr;
              ram_wdata = '0;
            end
            OP_QUERY: begin
              ram_re    = 1'b1;
              ram_raddr = id_addr;
            end
            default: begin
            end
          endcase
        end
      end
      S_TICK: begin
        ram_re = rd_go;
        ram_we = pend_r;
      end
      S_QWAIT: begin
      end
      default: begin
      end
    endcase
  end

  hct_ram #(
    .WIDTH (TIMER_W),
    .DEPTH (NUM_TIMERS),
    .ADDR_W(AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            q_addr_r <= id_addr;
            q_ok_r   <= id_ok;
            rd_idx_r <= '0;
            pend_r   <= 1'b0;
            unique case (in_item.operation)
              OP_TICK:  state_r <= S_TICK;
              OP_QUERY: state_r <= S_QWAIT;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_TICK: begin
          pend_r   <= rd_go;
          wr_idx_r <= rd_idx_r[AW-1:0];
          if (rd_go) begin
            rd_idx_r <= rd_idx_r + CW'(1);
          end
          if (!rd_go && !pend_r) begin
            state_r <= S_IDLE;
          end
        end
        S_QWAIT: begin
          out_valid_r <= 1'b1;
          out_item_r.running      <= q_ok_r & entry.running;
          out_item_r.seconds_left <= q_ok_r ? entry.seconds : 8'd0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.operation == OP_QUERY) |=> ##1 out_valid)
    else $error("query item without result strobe");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a query in flight");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("tick write-back collides with record read");

endmodule

`default_nettype wire

### rtl/hct_ram.sv
// hct_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module hct_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/hct_step_unit.sv
// hct_step_unit: one-second countdown step of a single timer record
// depends on hct_pkg
`default_nettype none

module hct_step_unit
  import hct_pkg::*;
(
  input  wire timer_t cur,
  output timer_t      nxt
);

  logic [7:0] sec_dec;

  assign sec_dec = cur.seconds - 8'd1;

  always_comb begin
    nxt = cur;
    if (cur.running) begin
      priority if (cur.seconds != 8'd0) begin
        nxt.seconds = sec_dec;
        if ((sec_dec | cur.minutes | cur.hours) == 8'd0) begin
          nxt.running = 1'b0;
        end
      end else if (cur.minutes != 8'd0) begin
        nxt.minutes = cur.minutes - 8'd1;
        nxt.seconds = LAST_UNIT;
      end else if (cur.hours != 8'd0) begin
        nxt.hours   = cur.hours - 8'd1;
        nxt.minutes = LAST_UNIT;
        nxt.seconds = LAST_UNIT;
      end
    end
  end

endmodule

`default_nettype wire

### verif/tb_hms_countdown_timer_bank_top.sv
// tb_hms_countdown_timer_bank_top: self-checking bench for the countdown timer bank
// directed and random items, with an in-bench predictor of the timer records and status reads
// depends on hct_pkg and hms_countdown_timer_bank_top
`default_nettype none

module tb_hms_countdown_timer_bank_top;
  import hct_pkg::*;

  localparam int NUM_TIMERS   = 8;
  localparam int DRAIN_CYCLES = NUM_TIMERS + 4;
  localparam int GAP_PCT      = 31;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  in_item_t  pend_q[$];
  out_item_t status_due_q[$];
  bit        no_gaps = 1'b0;

  int errors = 0;
  int items_taken = 0;
  int ticks_taken = 0;
  int statuses_checked = 0;
  int rundowns_seen = 0;

  logic       run_flag  [NUM_TIMERS];
  logic [7:0] hrs_left  [NUM_TIMERS];
  logic [7:0] mins_left [NUM_TIMERS];
  logic [7:0] secs_left [NUM_TIMERS];

  hms_countdown_timer_bank_top #(.NUM_TIMERS(NUM_TIMERS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  function automatic void tick_bank();
    for (int k = 0; k < NUM_TIMERS; k++) begin
      if (run_flag[k]) begin
        if (secs_left[k] != 8'd0) begin
          secs_left[k] = secs_left[k] - 8'd1;
          if ((secs_left[k] | mins_left[k] | hrs_left[k]) == 8'd0) begin
            run_flag[k] = 1'b0;
            rundowns_seen++;
          end
        end else if (mins_left[k] != 8'd0) begin
          mins_left[k] = mins_left[k] - 8'd1;
          secs_left[k] = LAST_UNIT;
        end else if (hrs_left[k] != 8'd0) begin
          hrs_left[k]  = hrs_left[k] - 8'd1;
          mins_left[k] = LAST_UNIT;
          secs_left[k] = LAST_UNIT;
        end
      end
    end
  endfunction

  function automatic void apply_timer_op(in_item_t it);
    out_item_t st;
    bit        hit;
    hit = int'(it.timer_id) < NUM_TIMERS;
    case (it.operation)
      OP_TICK: begin
        tick_bank();
        ticks_taken++;
      end
      OP_SET: begin
        if (hit) begin
          hrs_left[it.timer_id]  = it.hours;
          mins_left[it.timer_id] = it.minutes;
          secs_left[it.timer_id] = it.seconds;
          run_flag[it.timer_id]  = (it.hours | it.minutes | it.seconds) != 8'd0;
        end
      end
      OP_EXPIRE: begin
        if (hit) begin
          hrs_left[it.timer_id]  = 8'd0;
          mins_left[it.timer_id] = 8'd0;
          secs_left[it.timer_id] = 8'd0;
          run_flag[it.timer_id]  = 1'b0;
        end
      end
      default: begin
        st.running      = hit ? run_flag[it.timer_id] : 1'b0;
        st.seconds_left = hit ? secs_left[it.timer_id] : 8'd0;
        status_due_q.push_back(st);
      end
    endcase
  endfunction

  // driver: presents items from pend_q, holds each until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_timer_op(in_item);
        items_taken++;
      end
      if (!start || !busy) begin
        if (pend_q.size() != 0 && (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
          in_item <= pend_q.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: status strobes against the oldest expected status
  always @(posedge clk) begin : status_mon
    out_item_t want;
    if (rst_n && out_valid) begin
      if (status_due_q.size() == 0) begin
        $error("unexpected status: running %0d seconds_left %0d",
               out_item.running, out_item.seconds_left);
        errors++;
      end else begin
        want = status_due_q.pop_front();
        statuses_checked++;
        if (out_item.running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, out_item.running);
          errors++;
        end
        if (out_item.seconds_left !== want.seconds_left) begin
          $error("seconds_left: expected %0d, got %0d", want.seconds_left,
                 out_item.seconds_left);
          errors++;
        end
      end
    end
  end

  function automatic void push_item(logic [1:0] op, logic [2:0] id, logic [7:0] h,
                                    logic [7:0] m, logic [7:0] s);
    in_item_t it;
    it.operation = op;
    it.timer_id  = id;
    it.hours     = h;
    it.minutes   = m;
    it.seconds   = s;
    pend_q.push_back(it);
  endfunction

  // mostly short countdowns so timers run out, borrow and get re-armed often
  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned sel;
    int unsigned shape;
    it.timer_id = 3'($urandom_range(7));
    it.hours    = 8'($urandom_range(255));
    it.minutes  = 8'($urandom_range(255));
    it.seconds  = 8'($urandom_range(255));
    sel = $urandom_range(99);
    if (sel < 40) begin
      it.operation = OP_TICK;
    end else if (sel < 65) begin
      it.operation = OP_SET;
      shape = $urandom_range(9);
      if (shape < 4) begin
        it.hours   = 8'd0;
        it.minutes = 8'd0;
        it.seconds = 8'($urandom_range(4));
      end else if (shape < 6) begin
        it.hours   = 8'd0;
        it.minutes = 8'($urandom_range(2, 1));
        it.seconds = 8'($urandom_range(2));
      end else if (shape == 6) begin
        it.hours   = 8'd1;
        it.minutes = 8'd0;
        it.seconds = 8'd0;
      end else if (shape == 7) begin
        it.hours   = 8'd0;
        it.minutes = 8'd0;
        it.seconds = 8'd0;
      end
    end else if (sel < 72) begin
      it.operation = OP_EXPIRE;
    end else begin
      it.operation = OP_QUERY;
    end
    return it;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_q.size() != 0 || start || busy || status_due_q.size() != 0);
  endtask

  initial begin
    for (int k = 0; k < NUM_TIMERS; k++) begin
      run_flag[k]  = 1'b0;
      hrs_left[k]  = 8'd0;
      mins_left[k] = 8'd0;
      secs_left[k] = 8'd0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_item(OP_QUERY,  3'd0, 8'h00, 8'h00, 8'h00);
    push_item(OP_SET,    3'd0, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd0, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_SET,    3'd1, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_SET,    3'd2, 8'h00, 8'h00, 8'h01);
    push_item(OP_SET,    3'd3, 8'h00, 8'h01, 8'h00);
    push_item(OP_SET,    3'd4, 8'h01, 8'h00, 8'h00);
    push_item(OP_SET,    3'd6, 8'h55, 8'hAA, 8'h55);
    push_item(OP_SET,    3'd7, 8'hAA, 8'h55, 8'hAA);
    push_item(OP_TICK,   3'd7, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_QUERY,  3'd1, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd2, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd3, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd4, 8'h00, 8'h00, 8'h00);
    push_item(OP_SET,    3'd5, 8'h00, 8'h00, 8'd200);
    push_item(OP_EXPIRE, 3'd5, 8'hFF, 8'hFF, 8'hFF);
    push_item(OP_QUERY,  3'd5, 8'h00, 8'h00, 8'h00);
    push_item(OP_EXPIRE, 3'd2, 8'h00, 8'h00, 8'h00);
    push_item(OP_TICK,   3'd0, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd2, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd6, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd7, 8'h00, 8'h00, 8'h00);
    push_item(OP_QUERY,  3'd3, 8'h00, 8'h00, 8'h00);
    wait_idle();

    repeat (450) pend_q.push_back(rand_item());
    wait_idle();

    // back-to-back stretch
    no_gaps = 1'b1;
    repeat (300) pend_q.push_back(rand_item());
    wait_idle();
    no_gaps = 1'b0;

    repeat (400) pend_q.push_back(rand_item());
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (status_due_q.size() != 0) begin
      $error("status items: expected %0d more, got 0", status_due_q.size());
      errors++;
    end

    $display("ran %0d items incl. %0d ticks; %0d status reads checked", items_taken,
             ticks_taken, statuses_checked);
    $display("%0d timers counted down to zero on a tick", rundowns_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
